/* design/swb_pkg.sv */
// shared types, codes and constants for the single-wire bus slave
package swb_pkg;

    localparam int STORE_DEPTH_DEF = 64;
    localparam int ID_BYTES_DEF    = 4;
    localparam logic [7:0] ID_OFF  = 8'd3;

    // bit action flags and kinds
    localparam int AF_SAMPLE_B = 7;
    localparam int AF_LOW_B    = 6;
    localparam int AF_MUTE_B   = 5;

    localparam logic [3:0] K_IDLE  = 4'd0;
    localparam logic [3:0] K_SEND  = 4'd1;
    localparam logic [3:0] K_RECV  = 4'd2;
    localparam logic [3:0] K_ACK1  = 4'd3;
    localparam logic [3:0] K_ACK2  = 4'd4;
    localparam logic [3:0] K_NACK1 = 4'd5;
    localparam logic [3:0] K_NACK2 = 4'd6;
    localparam logic [3:0] K_READY = 4'd7;
    localparam logic [3:0] K_STALL = 4'd8;

    localparam logic [7:0] A_IDLE      = 8'h00;
    localparam logic [7:0] A_STALL     = 8'h48;
    localparam logic [7:0] A_SEND_HIGH = 8'h21;
    localparam logic [7:0] A_SEND_LOW  = 8'h61;
    localparam logic [7:0] A_SEND_CHK  = 8'hA1;
    localparam logic [7:0] A_RECV      = 8'h82;
    localparam logic [7:0] A_ACK1      = 8'h63;
    localparam logic [7:0] A_ACK2      = 8'h24;
    localparam logic [7:0] A_NACK1     = 8'h25;
    localparam logic [7:0] A_NACK2     = 8'h66;
    localparam logic [7:0] A_READY     = 8'h87;

    // control flag bit positions
    localparam int F_MUTE_B   = 0;
    localparam int F_PAR_B    = 1;
    localparam int F_ENUM_B   = 2;
    localparam int F_CHECK_B  = 3;
    localparam int F_SEND_B   = 4;
    localparam int F_IDLE_B   = 5;
    localparam int F_CLRMU_B  = 6;

    localparam logic [2:0] E_OK        = 3'd0;
    localparam logic [2:0] E_PARITY    = 3'd1;
    localparam logic [2:0] E_UNKNOWN   = 3'd2;
    localparam logic [2:0] E_RD_ADDR   = 3'd3;
    localparam logic [2:0] E_WR_ADDR   = 3'd4;
    localparam logic [2:0] E_READ_ONLY = 3'd5;

    localparam logic [7:0] CFG_ENUM_OP  = 8'd0;
    localparam logic [7:0] CFG_READ_OP  = 8'd1;
    localparam logic [7:0] CFG_WRITE_OP = 8'd2;
    localparam logic [7:0] CFG_UID      = 8'd3;

    typedef enum logic [3:0] {
        P_IDLE    = 4'd0,
        P_ADDR    = 4'd1,
        P_ENUM    = 4'd2,
        P_CMD     = 4'd3,
        P_RD_ADDR = 4'd4,
        P_RD_DATA = 4'd5,
        P_WR_ADDR = 4'd6,
        P_WR_DATA = 4'd7,
        P_RD_OVER = 4'd8
    } t_phase;

    typedef struct packed {
        logic [7:0] action;
        t_phase     phase;
        logic [7:0] shift;
        logic [7:0] mask;
        logic [7:0] ptr;
        logic [7:0] addr;
        logic [6:0] flags;
        logic [2:0] err;
    } t_state;

    typedef struct packed {
        logic [7:0]  enum_op;
        logic [7:0]  read_op;
        logic [7:0]  write_op;
        logic [63:0] uid;
    } t_cfg;

    typedef struct packed {
        logic command;
        logic line_high;
    } t_in;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       enumerated;
        logic [7:0] bus_address;
    } t_out;

endpackage

/* design/single_wire_bus_slave_with_enumeration.sv */
// top level of the single-wire bus slave: configuration, handshakes and result register
// Each transfer is a bit slot, bus reset or idle timeout and gives one result transfer.
// A new item is taken every clock cycle unless a result is stalled: the slot and byte
// handling is done in one pass from the protocol state registers into the result
// register, which frees itself in the cycle its transfer is taken. Store reads come
// from a memory with registered reads, fetched at the edge that fixes the read address.
module single_wire_bus_slave_with_enumeration #(
    parameter int STORE_DEPTH = swb_pkg::STORE_DEPTH_DEF,
    parameter int ID_BYTES    = swb_pkg::ID_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  swb_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output swb_pkg::t_out o_out,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [7:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    swb_pkg::t_cfg r_cfg;
    swb_pkg::t_out r_out, n_out;
    logic          r_out_valid;
    logic          in_acc;
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enum_op  <= 8'd1;
            r_cfg.read_op  <= 8'd2;
            r_cfg.write_op <= 8'd3;
            r_cfg.uid      <= 64'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                swb_pkg::CFG_ENUM_OP:  r_cfg.enum_op  <= i_cfg_data[7:0];
                swb_pkg::CFG_READ_OP:  r_cfg.read_op  <= i_cfg_data[7:0];
                swb_pkg::CFG_WRITE_OP: r_cfg.write_op <= i_cfg_data[7:0];
                swb_pkg::CFG_UID:      r_cfg.uid      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    swb_core #(
        .STORE_DEPTH (STORE_DEPTH),
        .ID_BYTES    (ID_BYTES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (in_acc),
        .i_item     (i_in),
        .i_cfg      (r_cfg),
        .i_mem_data (rd_data),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_addr  (rd_addr),
        .o_res      (n_out)
    );

    swb_store #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // bus reset starts a receive
    a_reset_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.command && !i_in.line_high |=> o_out.busy_res)
        else $error("bus reset did not start a transaction");

    // idle timeout ends any transaction
    a_idle_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.command && i_in.line_high |=> !o_out.busy_res)
        else $error("idle timeout left the slave busy");

    // never drive on a timeout
    a_timeout_nodrive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.command |=> !o_out.drive_low)
        else $error("line driven on a timeout");

    // every transfer in gives a result
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("no result after an input transfer");

endmodule

/* design/swb_store.sv */
// byte store with per-entry valid bits and registered read
module swb_store #(
    parameter int STORE_DEPTH = swb_pkg::STORE_DEPTH_DEF,
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0]             r_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] r_vld;
    logic [7:0]             r_rd_data;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : 8'h00;

endmodule

/* design/swb_core.sv */
// per-slot protocol state update and state register
module swb_core #(
    parameter int STORE_DEPTH = swb_pkg::STORE_DEPTH_DEF,
    parameter int ID_BYTES    = swb_pkg::ID_BYTES_DEF,
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_acc,
    input  swb_pkg::t_in  i_item,
    input  swb_pkg::t_cfg i_cfg,
    input  logic [7:0]    i_mem_data,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [7:0]    o_wr_data,
    output logic [AW-1:0] o_rd_addr,
    output swb_pkg::t_out o_res
);

    localparam logic [8:0] DEPTH9 = 9'(STORE_DEPTH);
    localparam logic [7:0] ID_END = 8'(int'(swb_pkg::ID_OFF) + ID_BYTES);

    swb_pkg::t_state r_st, n_st;
    swb_pkg::t_state s0, s1, s2;
    logic            drive;
    logic            hi;
    logic [7:0]      rd_ptr;

    function automatic logic in_id(input logic [7:0] p);
        return (p >= swb_pkg::ID_OFF) && (p < ID_END);
    endfunction

    function automatic logic in_store(input logic [7:0] p);
        return {1'b0, p} < DEPTH9;
    endfunction

    function automatic logic [7:0] store_rd(input logic [7:0] p, input logic [63:0] uid,
                                            input logic [7:0] mv);
        logic [2:0] k;
        k = 3'(p - swb_pkg::ID_OFF);
        if (in_id(p)) begin
            return uid[{k, 3'b000} +: 8];
        end else if (in_store(p)) begin
            return mv;
        end
        return 8'h00;
    endfunction

    function automatic swb_pkg::t_state load_bit(input swb_pkg::t_state s);
        swb_pkg::t_state t;
        logic            v;
        t = s;
        v = (s.mask != 8'h00) ? ((s.shift & s.mask) != 8'h00) : !s.flags[swb_pkg::F_PAR_B];
        if (!v) begin
            t.action = swb_pkg::A_SEND_LOW;
        end else begin
            t.action = s.flags[swb_pkg::F_CHECK_B] ? swb_pkg::A_SEND_CHK : swb_pkg::A_SEND_HIGH;
            t.flags[swb_pkg::F_PAR_B] = !s.flags[swb_pkg::F_PAR_B];
        end
        return t;
    endfunction

    function automatic swb_pkg::t_state slot_done(input swb_pkg::t_state s, input logic h);
        swb_pkg::t_state t;
        t = s;
        case (s.action[3:0])
            swb_pkg::K_RECV: begin
                if (h) begin
                    t.shift = s.shift | s.mask;
                    t.flags[swb_pkg::F_PAR_B] = !s.flags[swb_pkg::F_PAR_B];
                end
                if (s.mask != 8'h00) begin
                    t.mask = s.mask >> 1;
                end else if (t.flags[swb_pkg::F_PAR_B]) begin
                    t.action = swb_pkg::A_STALL;
                end else begin
                    t.action = swb_pkg::A_READY;
                    t.err    = swb_pkg::E_PARITY;
                end
            end
            swb_pkg::K_SEND: begin
                if (s.action[swb_pkg::AF_SAMPLE_B] && !h) begin
                    t.flags[swb_pkg::F_MUTE_B] = 1'b1;
                end
                if (s.mask == 8'h00) begin
                    if (s.err != swb_pkg::E_OK) begin
                        t.action = swb_pkg::A_READY;
                        t.err    = swb_pkg::E_OK;
                        t.flags[swb_pkg::F_IDLE_B] = 1'b1;
                    end else begin
                        t.action = swb_pkg::A_STALL;
                    end
                end else begin
                    t.mask = s.mask >> 1;
                    t = load_bit(t);
                end
            end
            swb_pkg::K_ACK1: t.action = swb_pkg::A_ACK2;
            swb_pkg::K_NACK1: t.action = swb_pkg::A_NACK2;
            swb_pkg::K_NACK2: t = load_bit(s);
            swb_pkg::K_ACK2: begin
                if (s.flags[swb_pkg::F_IDLE_B]) begin
                    t.action = swb_pkg::A_IDLE;
                end else begin
                    if (s.flags[swb_pkg::F_CLRMU_B]) begin
                        t.flags[swb_pkg::F_MUTE_B]  = 1'b0;
                        t.flags[swb_pkg::F_CLRMU_B] = 1'b0;
                    end
                    if (s.flags[swb_pkg::F_SEND_B]) begin
                        t = load_bit(t);
                    end else begin
                        t.action = swb_pkg::A_RECV;
                        t.shift  = 8'h00;
                    end
                end
            end
            swb_pkg::K_READY: begin
                if (h) begin
                    t.flags[swb_pkg::F_PAR_B] = 1'b0;
                    t.mask = 8'h80;
                    if (s.err != swb_pkg::E_OK) begin
                        t.action = swb_pkg::A_NACK1;
                        t.shift  = {5'd0, s.err};
                    end else begin
                        t.action = swb_pkg::A_ACK1;
                    end
                end
            end
            default: t = s;
        endcase
        return t;
    endfunction

    function automatic swb_pkg::t_state byte_done(input swb_pkg::t_state s,
                                                  input swb_pkg::t_cfg c,
                                                  input logic [7:0] mv);
        swb_pkg::t_state t;
        logic            fin;
        t   = s;
        fin = 1'b0;
        case (s.phase)
            swb_pkg::P_ADDR: begin
                if (s.shift == c.enum_op) begin
                    t.phase = swb_pkg::P_ENUM;
                    t.flags[swb_pkg::F_CHECK_B] = 1'b1;
                    t.flags[swb_pkg::F_SEND_B]  = 1'b1;
                    t.flags[swb_pkg::F_ENUM_B]  = 1'b0;
                    t.ptr  = swb_pkg::ID_OFF;
                    t.addr = 8'h00;
                end else if (s.flags[swb_pkg::F_ENUM_B] && s.shift == s.addr) begin
                    t.phase  = swb_pkg::P_CMD;
                    t.action = swb_pkg::A_READY;
                end else begin
                    t.action = swb_pkg::A_IDLE;
                end
            end
            swb_pkg::P_CMD: begin
                if (s.shift == c.read_op) begin
                    t.phase = swb_pkg::P_RD_ADDR;
                end else if (s.shift == c.write_op) begin
                    t.phase = swb_pkg::P_WR_ADDR;
                end else begin
                    t.err = swb_pkg::E_UNKNOWN;
                end
                t.action = swb_pkg::A_READY;
            end
            swb_pkg::P_RD_ADDR: begin
                t.ptr = s.shift;
                t.flags[swb_pkg::F_SEND_B] = 1'b1;
                t.phase = swb_pkg::P_RD_DATA;
                if (!in_store(s.shift)) begin
                    t.err    = swb_pkg::E_RD_ADDR;
                    t.action = swb_pkg::A_READY;
                end
            end
            swb_pkg::P_WR_ADDR: begin
                t.ptr    = s.shift;
                t.phase  = swb_pkg::P_WR_DATA;
                t.action = swb_pkg::A_READY;
                if (!in_store(s.shift)) begin
                    t.err = swb_pkg::E_RD_ADDR;
                end
            end
            swb_pkg::P_WR_DATA: begin
                if (!in_store(s.ptr)) begin
                    t.err = swb_pkg::E_WR_ADDR;
                end else if (in_id(s.ptr) && s.shift != store_rd(s.ptr, c.uid, mv)) begin
                    t.err = swb_pkg::E_READ_ONLY;
                end
                t.ptr    = s.ptr + 8'd1;
                t.action = swb_pkg::A_READY;
            end
            swb_pkg::P_ENUM: begin
                if (s.ptr == ID_END) begin
                    if (s.flags[swb_pkg::F_MUTE_B]) begin
                        t.ptr  = swb_pkg::ID_OFF;
                        t.addr = s.addr + 8'd1;
                        t.flags[swb_pkg::F_CLRMU_B] = 1'b1;
                    end else begin
                        t.phase = swb_pkg::P_IDLE;
                        t.flags[swb_pkg::F_IDLE_B] = 1'b1;
                        t.flags[swb_pkg::F_ENUM_B] = 1'b1;
                        t.action = swb_pkg::A_READY;
                        fin = 1'b1;
                    end
                end
                if (!fin) begin
                    if (!t.flags[swb_pkg::F_MUTE_B] || t.flags[swb_pkg::F_CLRMU_B]) begin
                        t.shift = store_rd(t.ptr, c.uid, mv);
                    end
                    t.ptr    = t.ptr + 8'd1;
                    t.action = swb_pkg::A_READY;
                end
            end
            swb_pkg::P_RD_DATA: begin
                if (!in_store(s.ptr)) begin
                    t.phase = swb_pkg::P_RD_OVER;
                end else begin
                    t.shift = store_rd(s.ptr, c.uid, mv);
                    t.ptr   = s.ptr + 8'd1;
                end
                t.action = swb_pkg::A_READY;
            end
            swb_pkg::P_RD_OVER: begin
                t.err    = swb_pkg::E_RD_ADDR;
                t.action = swb_pkg::A_READY;
            end
            default: t.action = swb_pkg::A_IDLE;
        endcase
        return t;
    endfunction

    assign hi = i_item.line_high;

    always_comb begin
        s0    = r_st;
        s1    = r_st;
        s2    = r_st;
        n_st  = r_st;
        drive = 1'b0;
        if (i_item.command) begin
            if (hi) begin
                n_st.action = swb_pkg::A_IDLE;
            end else begin
                n_st.phase  = swb_pkg::P_ADDR;
                n_st.action = swb_pkg::A_RECV;
                n_st.err    = swb_pkg::E_OK;
                n_st.shift  = 8'h00;
                n_st.mask   = 8'h80;
                n_st.flags  = r_st.flags & (7'd1 << swb_pkg::F_ENUM_B);
            end
        end else begin
            if (r_st.flags[swb_pkg::F_MUTE_B] && r_st.action[swb_pkg::AF_MUTE_B]) begin
                s0.action[swb_pkg::AF_LOW_B]    = 1'b0;
                s0.action[swb_pkg::AF_SAMPLE_B] = 1'b0;
            end
            drive = s0.action[swb_pkg::AF_LOW_B];
            s1 = slot_done(s0, hi);
            s2 = (s1.action == swb_pkg::A_STALL) ? byte_done(s1, i_cfg, i_mem_data) : s1;
            n_st = (s2.action == swb_pkg::A_STALL) ? byte_done(s2, i_cfg, i_mem_data) : s2;
            if (n_st.action == swb_pkg::A_STALL) begin
                n_st.action = swb_pkg::A_IDLE;
            end
        end
    end

    // store write: a data byte in range and outside the identity bytes
    assign o_wr_en = i_acc && !i_item.command && s1.action == swb_pkg::A_STALL
                     && s1.phase == swb_pkg::P_WR_DATA && in_store(s1.ptr) && !in_id(s1.ptr);
    assign o_wr_addr = s1.ptr[AW-1:0];
    assign o_wr_data = s1.shift;

    // fetch for the next read byte, from the state being stored
    assign rd_ptr = i_acc ? ((n_st.phase == swb_pkg::P_RD_ADDR) ? n_st.shift : n_st.ptr)
                          : ((r_st.phase == swb_pkg::P_RD_ADDR) ? r_st.shift : r_st.ptr);
    assign o_rd_addr = rd_ptr[AW-1:0];

    assign o_res.drive_low   = drive;
    assign o_res.busy_res    = n_st.action != swb_pkg::A_IDLE;
    assign o_res.enumerated  = n_st.flags[swb_pkg::F_ENUM_B];
    assign o_res.bus_address = n_st.addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.action <= swb_pkg::A_IDLE;
            r_st.phase  <= swb_pkg::P_IDLE;
            r_st.shift  <= 8'h00;
            r_st.mask   <= 8'h00;
            r_st.ptr    <= 8'h00;
            r_st.addr   <= 8'h00;
            r_st.flags  <= '0;
            r_st.err    <= swb_pkg::E_OK;
        end else if (i_acc) begin
            r_st <= n_st;
        end
    end

endmodule

/* sim/swb_checker.sv */
// checker for the single-wire bus slave: predicts each result transfer and compares it
module swb_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  swb_pkg::t_in  i_in,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  swb_pkg::t_out i_out,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_ready,
    input  logic [7:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data,
    output int            o_errors,
    output int            o_pending,
    output logic [7:0]    o_own_addr
);

    localparam int DEPTH = swb_pkg::STORE_DEPTH_DEF;
    localparam int ID_LO = int'(swb_pkg::ID_OFF);
    localparam int ID_HI = int'(swb_pkg::ID_OFF) + swb_pkg::ID_BYTES_DEF;

    logic [7:0]  op_enum, op_read, op_write;
    logic [63:0] uid;

    logic [7:0]      act;
    swb_pkg::t_phase phase;
    logic [7:0]      shreg, msk, ptr, own_addr;
    logic [6:0]      flg;
    logic [2:0]      err;
    logic [7:0]      mem [DEPTH];

    swb_pkg::t_out exp_results [$];
    int            mismatches;

    assign o_errors   = mismatches;
    assign o_pending  = exp_results.size();
    assign o_own_addr = own_addr;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    function automatic logic is_id(input logic [7:0] p);
        return int'(p) >= ID_LO && int'(p) < ID_HI;
    endfunction

    function automatic logic [7:0] store_byte(input logic [7:0] p);
        if (is_id(p)) return 8'(uid >> (8 * (int'(p) - ID_LO)));
        if (int'(p) < DEPTH) return mem[p];
        return 8'h00;
    endfunction

    function automatic void load_bit();
        logic v;
        if (msk != 0) v = |(shreg & msk);
        else v = !flg[swb_pkg::F_PAR_B];
        if (!v) begin
            act = swb_pkg::A_SEND_LOW;
        end else begin
            act = flg[swb_pkg::F_CHECK_B] ? swb_pkg::A_SEND_CHK : swb_pkg::A_SEND_HIGH;
            flg[swb_pkg::F_PAR_B] = !flg[swb_pkg::F_PAR_B];
        end
    endfunction

    function automatic void finish_slot(input logic hi);
        case (act[3:0])
            swb_pkg::K_RECV: begin
                if (hi) begin
                    shreg = shreg | msk;
                    flg[swb_pkg::F_PAR_B] = !flg[swb_pkg::F_PAR_B];
                end
                if (msk != 0) msk = msk >> 1;
                else if (flg[swb_pkg::F_PAR_B]) act = swb_pkg::A_STALL;
                else begin
                    act = swb_pkg::A_READY;
                    err = swb_pkg::E_PARITY;
                end
            end
            swb_pkg::K_SEND: begin
                if (act[swb_pkg::AF_SAMPLE_B] && !hi) flg[swb_pkg::F_MUTE_B] = 1'b1;
                if (msk == 0) begin
                    if (err != swb_pkg::E_OK) begin
                        act = swb_pkg::A_READY;
                        err = swb_pkg::E_OK;
                        flg[swb_pkg::F_IDLE_B] = 1'b1;
                    end else begin
                        act = swb_pkg::A_STALL;
                    end
                end else begin
                    msk = msk >> 1;
                    load_bit();
                end
            end
            swb_pkg::K_ACK1:  act = swb_pkg::A_ACK2;
            swb_pkg::K_NACK1: act = swb_pkg::A_NACK2;
            swb_pkg::K_NACK2: load_bit();
            swb_pkg::K_ACK2: begin
                if (flg[swb_pkg::F_IDLE_B]) begin
                    act = swb_pkg::A_IDLE;
                end else begin
                    if (flg[swb_pkg::F_CLRMU_B]) begin
                        flg[swb_pkg::F_MUTE_B] = 1'b0;
                        flg[swb_pkg::F_CLRMU_B] = 1'b0;
                    end
                    if (flg[swb_pkg::F_SEND_B]) load_bit();
                    else begin
                        act = swb_pkg::A_RECV;
                        shreg = 8'h00;
                    end
                end
            end
            swb_pkg::K_READY: begin
                if (hi) begin
                    flg[swb_pkg::F_PAR_B] = 1'b0;
                    msk = 8'h80;
                    if (err != swb_pkg::E_OK) begin
                        act = swb_pkg::A_NACK1;
                        shreg = 8'(err);
                    end else begin
                        act = swb_pkg::A_ACK1;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void finish_byte();
        case (phase)
            swb_pkg::P_ADDR: begin
                if (shreg == op_enum) begin
                    phase = swb_pkg::P_ENUM;
                    flg[swb_pkg::F_CHECK_B] = 1'b1;
                    flg[swb_pkg::F_SEND_B] = 1'b1;
                    flg[swb_pkg::F_ENUM_B] = 1'b0;
                    ptr = swb_pkg::ID_OFF;
                    own_addr = 8'h00;
                end else if (flg[swb_pkg::F_ENUM_B] && shreg == own_addr) begin
                    phase = swb_pkg::P_CMD;
                    act = swb_pkg::A_READY;
                end else begin
                    act = swb_pkg::A_IDLE;
                end
            end
            swb_pkg::P_CMD: begin
                if (shreg == op_read) phase = swb_pkg::P_RD_ADDR;
                else if (shreg == op_write) phase = swb_pkg::P_WR_ADDR;
                else err = swb_pkg::E_UNKNOWN;
                act = swb_pkg::A_READY;
            end
            swb_pkg::P_RD_ADDR: begin
                ptr = shreg;
                flg[swb_pkg::F_SEND_B] = 1'b1;
                phase = swb_pkg::P_RD_DATA;
                if (int'(ptr) >= DEPTH) begin
                    err = swb_pkg::E_RD_ADDR;
                    act = swb_pkg::A_READY;
                end
            end
            swb_pkg::P_WR_ADDR: begin
                ptr = shreg;
                phase = swb_pkg::P_WR_DATA;
                act = swb_pkg::A_READY;
                if (int'(ptr) >= DEPTH) err = swb_pkg::E_RD_ADDR;
            end
            swb_pkg::P_WR_DATA: begin
                if (int'(ptr) >= DEPTH) err = swb_pkg::E_WR_ADDR;
                else if (shreg != store_byte(ptr)) begin
                    if (is_id(ptr)) err = swb_pkg::E_READ_ONLY;
                    else mem[ptr] = shreg;
                end
                ptr = ptr + 8'd1;
                act = swb_pkg::A_READY;
            end
            swb_pkg::P_ENUM: begin
                if (int'(ptr) == ID_HI && !flg[swb_pkg::F_MUTE_B]) begin
                    phase = swb_pkg::P_IDLE;
                    flg[swb_pkg::F_IDLE_B] = 1'b1;
                    flg[swb_pkg::F_ENUM_B] = 1'b1;
                    act = swb_pkg::A_READY;
                end else begin
                    if (int'(ptr) == ID_HI) begin
                        ptr = swb_pkg::ID_OFF;
                        own_addr = own_addr + 8'd1;
                        flg[swb_pkg::F_CLRMU_B] = 1'b1;
                    end
                    if (!flg[swb_pkg::F_MUTE_B] || flg[swb_pkg::F_CLRMU_B])
                        shreg = store_byte(ptr);
                    ptr = ptr + 8'd1;
                    act = swb_pkg::A_READY;
                end
            end
            swb_pkg::P_RD_DATA: begin
                if (int'(ptr) >= DEPTH) phase = swb_pkg::P_RD_OVER;
                else begin
                    shreg = store_byte(ptr);
                    ptr = ptr + 8'd1;
                end
                act = swb_pkg::A_READY;
            end
            swb_pkg::P_RD_OVER: begin
                err = swb_pkg::E_RD_ADDR;
                act = swb_pkg::A_READY;
            end
            default: act = swb_pkg::A_IDLE;
        endcase
    endfunction

    function automatic swb_pkg::t_out step_slave(input swb_pkg::t_in item);
        swb_pkg::t_out r;
        r.drive_low = 1'b0;
        if (item.command) begin
            if (item.line_high) begin
                act = swb_pkg::A_IDLE;
            end else begin
                phase = swb_pkg::P_ADDR;
                act = swb_pkg::A_RECV;
                err = swb_pkg::E_OK;
                shreg = 8'h00;
                msk = 8'h80;
                flg = flg & (7'd1 << swb_pkg::F_ENUM_B);
            end
        end else begin
            if (flg[swb_pkg::F_MUTE_B] && act[swb_pkg::AF_MUTE_B]) begin
                act[swb_pkg::AF_LOW_B] = 1'b0;
                act[swb_pkg::AF_SAMPLE_B] = 1'b0;
            end
            r.drive_low = act[swb_pkg::AF_LOW_B];
            finish_slot(item.line_high);
            for (int i = 0; i < 4; i++)
                if (act == swb_pkg::A_STALL) finish_byte();
            if (act == swb_pkg::A_STALL) act = swb_pkg::A_IDLE;
        end
        r.busy_res    = act != swb_pkg::A_IDLE;
        r.enumerated  = flg[swb_pkg::F_ENUM_B];
        r.bus_address = own_addr;
        return r;
    endfunction

    always @(posedge i_clk) begin
        swb_pkg::t_out want;
        if (!i_rst_n) begin
            op_enum  = 8'd1;
            op_read  = 8'd2;
            op_write = 8'd3;
            uid      = '0;
            act      = swb_pkg::A_IDLE;
            phase    = swb_pkg::P_IDLE;
            shreg    = '0;
            msk      = '0;
            ptr      = '0;
            own_addr = '0;
            flg      = '0;
            err      = swb_pkg::E_OK;
            for (int i = 0; i < DEPTH; i++) mem[i] = 8'h00;
            exp_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (exp_results.size() == 0) begin
                    report("unexpected transfer", 64'(i_out), 64'd0);
                end else begin
                    want = exp_results.pop_front();
                    if (i_out.drive_low !== want.drive_low)
                        report("drive_low", 64'(i_out.drive_low), 64'(want.drive_low));
                    if (i_out.busy_res !== want.busy_res)
                        report("busy_res", 64'(i_out.busy_res), 64'(want.busy_res));
                    if (i_out.enumerated !== want.enumerated)
                        report("enumerated", 64'(i_out.enumerated), 64'(want.enumerated));
                    if (i_out.bus_address !== want.bus_address)
                        report("bus_address", 64'(i_out.bus_address),
                               64'(want.bus_address));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    swb_pkg::CFG_ENUM_OP:  op_enum = i_cfg_data[7:0];
                    swb_pkg::CFG_READ_OP:  op_read = i_cfg_data[7:0];
                    swb_pkg::CFG_WRITE_OP: op_write = i_cfg_data[7:0];
                    swb_pkg::CFG_UID:      uid = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) exp_results.push_back(step_slave(i_in));
        end
    end

    initial mismatches = 0;

endmodule

/* sim/tb.sv */
// testbench top for the single-wire bus slave: bus master stimulus, stalls and verdict
module tb;

    localparam int LIMIT = 3000000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    swb_pkg::t_in  in_item = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    swb_pkg::t_out out_item;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [7:0]    cfg_index = '0;
    logic [63:0]   cfg_data = '0;

    int          errors, pending;
    logic [7:0]  own_addr;
    int          cycles = 0;
    int          items = 0;
    int          stall_left = 0;
    logic        calm_in = 1'b0, calm_out = 1'b0;
    logic [7:0]  cur_enum = 8'd1, cur_read = 8'd2, cur_write = 8'd3;

    always #6 i_clk = ~i_clk;

    single_wire_bus_slave_with_enumeration u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out(out_item),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    swb_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in(in_item),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out(out_item),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_own_addr(own_addr)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side stalls, with calm stretches
    always @(posedge i_clk) begin
        int draw;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (out_valid && out_ready) begin
            if ($urandom_range(0, 63) == 0) calm_out = !calm_out;
            draw = calm_out ? 0 : $urandom_range(0, 17);
            stall_left = draw;
            out_ready <= draw == 0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_ready <= stall_left == 0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic put_item(input logic cmd, input logic hi);
        int gap;
        if ($urandom_range(0, 63) == 0) calm_in = !calm_in;
        gap = calm_in ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= '{command: cmd, line_high: hi};
        do @(posedge i_clk); while (!in_ready);
        items++;
    endtask

    task automatic slot(input logic hi);
        put_item(1'b0, hi);
    endtask

    // ready bit, sometimes held low first, then the two handshake slots
    task automatic handshake();
        if ($urandom_range(0, 9) == 0) slot(1'b0);
        slot(1'b1);
        slot(1'($urandom_range(0, 1)));
        slot(1'($urandom_range(0, 1)));
    endtask

    task automatic send_byte(input logic [7:0] b);
        logic bad;
        bad = $urandom_range(0, 32) == 0;
        for (int i = 7; i >= 0; i--) slot(b[i]);
        slot(~^b ^ bad);
        handshake();
    endtask

    task automatic take_byte(input logic clean);
        for (int i = 0; i < 9; i++) slot(clean ? 1'b1 : ($urandom_range(0, 9) != 0));
        handshake();
    endtask

    task automatic transaction();
        int kind, n;
        logic clean;
        logic [7:0] off;
        kind = $urandom_range(0, 9);
        clean = 1'($urandom_range(0, 1));
        if (kind == 9) begin
            n = $urandom_range(5, 20);
            repeat (n) put_item($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
            return;
        end
        put_item(1'b1, 1'b0);
        if (kind < 2) begin
            send_byte(cur_enum);
            n = $urandom_range(4, 14);
            repeat (n) take_byte(clean);
        end else begin
            send_byte($urandom_range(0, 4) != 0 ? own_addr : 8'($urandom));
            if ($urandom_range(0, 6) == 0) send_byte(8'($urandom));
            else send_byte(kind < 6 ? cur_read : cur_write);
            case ($urandom_range(0, 6))
                0:       off = 8'($urandom_range(56, 63));
                1:       off = 8'($urandom);
                default: off = 8'($urandom_range(0, 15));
            endcase
            send_byte(off);
            n = $urandom_range(1, 5);
            repeat (n) begin
                if (kind < 6) take_byte(clean);
                else send_byte($urandom_range(0, 3) == 0 ? 8'hff : 8'($urandom));
            end
        end
        put_item(1'b1, 1'b1);
    endtask

    task automatic cfg_write(input logic [7:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] e, input logic [7:0] r, input logic [7:0] w,
                              input logic [63:0] id);
        drain();
        cfg_write(swb_pkg::CFG_ENUM_OP, 64'(e));
        cfg_write(swb_pkg::CFG_READ_OP, 64'(r));
        cfg_write(swb_pkg::CFG_WRITE_OP, 64'(w));
        cfg_write(swb_pkg::CFG_UID, id);
        cur_enum = e;
        cur_read = r;
        cur_write = w;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle timeout, enumeration, read past the store end, read-only write, bad offsets
        put_item(1'b1, 1'b1);
        put_item(1'b1, 1'b0);
        send_byte(cur_enum);
        repeat (5) take_byte(1'b1);
        put_item(1'b1, 1'b0);
        send_byte(own_addr);
        send_byte(cur_read);
        send_byte(8'd62);
        repeat (3) take_byte(1'b1);
        put_item(1'b1, 1'b0);
        send_byte(own_addr);
        send_byte(cur_write);
        send_byte(8'd3);
        send_byte(8'h5a);
        put_item(1'b1, 1'b0);
        send_byte(own_addr);
        send_byte(cur_write);
        send_byte(8'd200);
        send_byte(8'h00);
        put_item(1'b1, 1'b1);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: ;
                1: set_config(8'h00, 8'hff, 8'hff, 64'hffff_ffff_ffff_ffff);
                2: set_config(8'hff, 8'h00, 8'h80, 64'h0);
                3: set_config(8'h07, 8'h07, 8'h09, {$urandom, $urandom});
                4: set_config(8'h55, 8'haa, 8'h00, 64'h8001_a5a5_7e01_00ff);
                default: set_config(8'($urandom), 8'($urandom), 8'($urandom),
                                    {$urandom, $urandom});
            endcase
            while (items < 300 * (ph + 1)) transaction();
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
